// ===== design/fcbm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbm_pkg
// Shared types and constants of the block-chain allocation table manager.
// ----------------------------------------------------------------------------
package fcbm_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int BLK_W      = 10;
    localparam int STEP_W     = BLK_W + 1;
    localparam int TB_W       = 11;
    localparam int RB_W       = 10;
    localparam int KEY_W      = 16;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

    // request codes
    localparam logic [2:0] FN_FORMAT = 3'd0;
    localparam logic [2:0] FN_CREATE = 3'd1;
    localparam logic [2:0] FN_APPEND = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_CHECK  = 3'd4;
    localparam logic [2:0] FN_NEXT   = 3'd5;
    localparam logic [2:0] FN_REMOVE = 3'd6;
    localparam logic [2:0] FN_FIRST  = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_EXISTS   = 3'd3;
    localparam logic [2:0] ST_DIRFULL  = 3'd4;
    localparam logic [2:0] ST_NOTIN    = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_FMT_INIT = 4'd1;
    localparam logic [3:0] OP_FMT_STEP = 4'd2;
    localparam logic [3:0] OP_LOAD     = 4'd3;
    localparam logic [3:0] OP_SCAN     = 4'd4;
    localparam logic [3:0] OP_CREATE   = 4'd5;
    localparam logic [3:0] OP_RD_HEAD  = 4'd6;
    localparam logic [3:0] OP_UNLINK   = 4'd7;
    localparam logic [3:0] OP_RD_N     = 4'd8;
    localparam logic [3:0] OP_ADV      = 4'd9;
    localparam logic [3:0] OP_LINK     = 4'd10;
    localparam logic [3:0] OP_WALK_INIT = 4'd11;
    localparam logic [3:0] OP_FIND_ADV = 4'd12;
    localparam logic [3:0] OP_DEL_LINK = 4'd13;
    localparam logic [3:0] OP_FREE_N   = 4'd14;
    localparam logic [3:0] OP_CLEAR    = 4'd15;

    // result value sources
    localparam logic [1:0] SEL_ZERO  = 2'd0;
    localparam logic [1:0] SEL_A     = 2'd1;
    localparam logic [1:0] SEL_RD    = 2'd2;
    localparam logic [1:0] SEL_FIRST = 2'd3;

    typedef struct packed {
        logic [2:0]       func;
        logic [KEY_W-1:0] file_key;
        logic [BLK_W-1:0] block_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [BLK_W-1:0] block_value;
    } t_out_item;

    typedef struct packed {
        logic [3:0] op;
        logic       res_en;
        logic [2:0] res_status;
        logic [1:0] res_sel;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       scan_match;
        logic       scan_last;
        logic       hit;
        logic       has_free;
        logic       first_zero;
        logic       head_zero;
        logic       blk_zero;
        logic       n_zero;
        logic       n_eq_blk;
        logic       steps_done;
        logic       rd_zero;
        logic       fmt_last;
        logic       out_free;
    } t_stat;

endpackage

// ===== design/fat_chain_block_manager.sv =====
// ----------------------------------------------------------------------------
// fat_chain_block_manager
// Block-chain allocation table with a free list and a small file directory.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request first scans the directory, one
// slot per cycle, stopping at the matching key or at the last slot, then runs
// its operation against the table memory (one read port, one write port):
// append and the chain lookups (delete, check, next) read each block walked
// and then advance, remove reads each block freed and then frees it, and
// create and first need no walk. Every walk is capped at 1024 steps.
// Format rewrites every table entry, one per cycle; the same sweep runs
// after reset, during which o_in_stall stays high. The
// result sits in an output register, so it may wait for the sink while the
// block returns to idle and takes the next request. Register writes to
// total_blocks and reserved_blocks take effect at the next format.
// ----------------------------------------------------------------------------
module fat_chain_block_manager #(
    parameter int DIR_SLOTS = 16,
    parameter int KEY_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  fcbm_pkg::t_in_item               i_in_item,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fcbm_pkg::t_out_item              o_out_item,
    // register write port
    input  logic                             i_cfg_we,
    input  logic [fcbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcbm_pkg::CFG_W-1:0]       i_cfg_data
);
    import fcbm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: owns the request handshake and steps each operation
    fcbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: table memory, directory, walk state and result register
    fcbm_datapath #(
        .DIR_SLOTS (DIR_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/fcbm_datapath.sv =====
// ----------------------------------------------------------------------------
// fcbm_datapath
// Table memory, directory, walk registers, config and result registers.
// ----------------------------------------------------------------------------
module fcbm_datapath #(
    parameter int DIR_SLOTS = 16,
    parameter int KEY_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fcbm_pkg::t_cmd                   i_cmd,
    output fcbm_pkg::t_stat                  o_stat,
    input  fcbm_pkg::t_in_item               i_in_item,
    input  logic                             i_cfg_we,
    input  logic [fcbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcbm_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fcbm_pkg::t_out_item              o_out_item
);
    import fcbm_pkg::*;

    localparam int SW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [SW-1:0] SLOT_LAST = SW'(DIR_SLOTS - 1);

    // configuration
    logic [TB_W-1:0] r_tb;
    logic [RB_W-1:0] r_rb;
    // clamped format bounds
    logic [TB_W-1:0] r_t, r_r;
    logic [BLK_W-1:0] r_fcnt;

    // request
    logic [2:0]       r_func;
    logic [KW-1:0]    r_key;
    logic [BLK_W-1:0] r_blk;

    // directory
    logic [KW-1:0]    dir_key   [DIR_SLOTS];
    logic             dir_used  [DIR_SLOTS];
    logic [BLK_W-1:0] dir_first [DIR_SLOTS];
    logic [SW-1:0]    r_slot, r_free;
    logic             r_hit, r_has_free;

    // walk
    logic [BLK_W-1:0]  r_head, r_a, r_n, r_p;
    logic [STEP_W-1:0] r_steps;

    // table memory
    logic [BLK_W-1:0] mem [MAX_BLOCKS];
    logic [BLK_W-1:0] r_rd;
    logic [BLK_W-1:0] rd_addr, wr_addr, wr_data;
    logic             wr_en;

    // result
    logic [2:0]       r_res_status;
    logic [BLK_W-1:0] r_res_value;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             scan_match;
    logic [TB_W-1:0]  tb_lim, rb_lim, fidx, fval;
    logic [BLK_W-1:0] res_val;

    assign scan_match = dir_used[r_slot] && (dir_key[r_slot] == r_key);

    always_comb begin
        tb_lim = r_tb;
        if (r_tb < TB_W'(2)) begin
            tb_lim = TB_W'(2);
        end else if (r_tb > TB_W'(MAX_BLOCKS)) begin
            tb_lim = TB_W'(MAX_BLOCKS);
        end
        rb_lim = {1'b0, r_rb};
        if (rb_lim > tb_lim - TB_W'(1)) begin
            rb_lim = tb_lim - TB_W'(1);
        end
    end

    // format value of one table entry
    always_comb begin
        fidx = {1'b0, r_fcnt};
        fval = '0;
        if (fidx != '0 && fidx <= r_r) begin
            fval = fidx;
        end else if (fidx > r_r && fidx < r_t) begin
            fval = (fidx + TB_W'(1) < r_t) ? fidx + TB_W'(1) : '0;
        end
    end

    always_comb begin
        unique case (i_cmd.res_sel)
            SEL_A:     res_val = r_a;
            SEL_RD:    res_val = r_rd;
            SEL_FIRST: res_val = dir_first[r_slot];
            default:   res_val = '0;
        endcase
    end

    always_comb begin
        rd_addr = (i_cmd.op == OP_RD_HEAD) ? r_head : r_n;
        wr_en   = 1'b0;
        wr_addr = r_n;
        wr_data = r_head;
        unique case (i_cmd.op)
            OP_FMT_STEP: begin
                wr_en   = 1'b1;
                wr_addr = r_fcnt;
                wr_data = fval[BLK_W-1:0];
            end
            OP_UNLINK: begin
                wr_en   = 1'b1;
                wr_addr = r_a;
                wr_data = '0;
            end
            OP_LINK: begin
                wr_en   = 1'b1;
                wr_addr = r_n;
                wr_data = r_a;
            end
            OP_DEL_LINK: begin
                wr_en   = (r_p != '0);
                wr_addr = r_p;
                wr_data = r_rd;
            end
            OP_FREE_N: begin
                wr_en   = 1'b1;
                wr_addr = r_n;
                wr_data = r_head;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb <= TB_W'(MAX_BLOCKS);
            r_rb <= RB_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TOTAL) begin
                r_tb <= i_cfg_data[TB_W-1:0];
            end else if (i_cfg_idx == CFG_RESERVED) begin
                r_rb <= i_cfg_data[RB_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIR_SLOTS; s++) begin
                dir_used[s]  <= 1'b0;
                dir_first[s] <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_FMT_INIT: begin
                    for (int s = 0; s < DIR_SLOTS; s++) begin
                        dir_used[s]  <= 1'b0;
                        dir_first[s] <= '0;
                    end
                end
                OP_CREATE: begin
                    dir_used[r_free]  <= 1'b1;
                    dir_key[r_free]   <= r_key;
                    dir_first[r_free] <= '0;
                end
                OP_UNLINK: begin
                    if (dir_first[r_slot] == '0) begin
                        dir_first[r_slot] <= r_a;
                    end
                end
                OP_DEL_LINK: begin
                    if (r_p == '0) begin
                        dir_first[r_slot] <= r_rd;
                    end
                end
                OP_CLEAR: begin
                    dir_used[r_slot]  <= 1'b0;
                    dir_first[r_slot] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_FMT_INIT: begin
                r_t    <= tb_lim;
                r_r    <= rb_lim;
                r_fcnt <= '0;
                r_head <= (rb_lim + TB_W'(1) < tb_lim) ?
                          BLK_W'(rb_lim + TB_W'(1)) : '0;
            end
            OP_FMT_STEP: begin
                r_fcnt <= r_fcnt + BLK_W'(1);
            end
            OP_LOAD: begin
                r_func     <= i_in_item.func;
                r_key      <= i_in_item.file_key[KW-1:0];
                r_blk      <= i_in_item.block_number;
                r_slot     <= '0;
                r_hit      <= 1'b0;
                r_has_free <= 1'b0;
            end
            OP_SCAN: begin
                if (scan_match) begin
                    r_hit <= 1'b1;
                end else begin
                    if (!dir_used[r_slot] && !r_has_free) begin
                        r_free     <= r_slot;
                        r_has_free <= 1'b1;
                    end
                    if (r_slot != SLOT_LAST) begin
                        r_slot <= r_slot + SW'(1);
                    end
                end
            end
            OP_RD_HEAD: begin
                r_a <= r_head;
            end
            OP_UNLINK: begin
                r_head  <= r_rd;
                r_n     <= dir_first[r_slot];
                r_steps <= '0;
            end
            OP_ADV: begin
                r_n     <= r_rd;
                r_steps <= r_steps + STEP_W'(1);
            end
            OP_WALK_INIT: begin
                r_n     <= dir_first[r_slot];
                r_p     <= '0;
                r_steps <= '0;
            end
            OP_FIND_ADV: begin
                r_p     <= r_n;
                r_n     <= r_rd;
                r_steps <= r_steps + STEP_W'(1);
            end
            OP_FREE_N: begin
                // push the block on the free list and move to its successor
                r_head  <= r_n;
                r_n     <= r_rd;
                r_steps <= r_steps + STEP_W'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.res_en) begin
            r_res_status <= i_cmd.res_status;
            r_res_value  <= (i_cmd.res_status == ST_OK) ? res_val : '0;
        end
        if (i_cmd.publish) begin
            r_out.status      <= r_res_status;
            r_out.block_value <= r_res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        o_stat.func       = r_func;
        o_stat.scan_match = scan_match;
        o_stat.scan_last  = (r_slot == SLOT_LAST);
        o_stat.hit        = r_hit;
        o_stat.has_free   = r_has_free;
        o_stat.first_zero = (dir_first[r_slot] == '0);
        o_stat.head_zero  = (r_head == '0);
        o_stat.blk_zero   = (r_blk == '0);
        o_stat.n_zero     = (r_n == '0);
        o_stat.n_eq_blk   = (r_n == r_blk);
        o_stat.steps_done = (r_steps == STEP_W'(MAX_BLOCKS));
        o_stat.rd_zero    = (r_rd == '0);
        o_stat.fmt_last   = (r_fcnt == BLK_W'(MAX_BLOCKS - 1));
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule

// ===== design/fcbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcbm_ctrl
// Request sequencer: scan, dispatch, chain walks, format sweep, reply.
// ----------------------------------------------------------------------------
module fcbm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fcbm_pkg::t_stat i_stat,
    output fcbm_pkg::t_cmd  o_cmd
);
    import fcbm_pkg::*;

    localparam logic [3:0] S_FMT_INIT   = 4'd0;
    localparam logic [3:0] S_FMT        = 4'd1;
    localparam logic [3:0] S_IDLE       = 4'd2;
    localparam logic [3:0] S_SCAN       = 4'd3;
    localparam logic [3:0] S_DISP       = 4'd4;
    localparam logic [3:0] S_RESULT     = 4'd5;
    localparam logic [3:0] S_APP_UNLINK = 4'd6;
    localparam logic [3:0] S_APP_RD     = 4'd7;
    localparam logic [3:0] S_APP_EVAL   = 4'd8;
    localparam logic [3:0] S_FIND_TEST  = 4'd9;
    localparam logic [3:0] S_FIND_ADV   = 4'd10;
    localparam logic [3:0] S_NEXT_OUT   = 4'd11;
    localparam logic [3:0] S_DEL_LINK   = 4'd12;
    localparam logic [3:0] S_DEL_FREE   = 4'd13;
    localparam logic [3:0] S_REM_TEST   = 4'd14;
    localparam logic [3:0] S_REM_STEP   = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_reply, n_reply;

    always_comb begin
        n_state          = r_state;
        n_reply          = r_reply;
        o_cmd.op         = OP_NONE;
        o_cmd.res_en     = 1'b0;
        o_cmd.res_status = ST_OK;
        o_cmd.res_sel    = SEL_ZERO;
        o_cmd.publish    = 1'b0;
        unique case (r_state)
            S_FMT_INIT: begin
                o_cmd.op = OP_FMT_INIT;
                n_state  = S_FMT;
            end
            S_FMT: begin
                o_cmd.op = OP_FMT_STEP;
                if (i_stat.fmt_last) begin
                    n_state = r_reply ? S_RESULT : S_IDLE;
                    n_reply = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.scan_match || i_stat.scan_last) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_en = 1'b1;
                n_state      = S_RESULT;
                priority if (i_stat.func == FN_FORMAT) begin
                    n_reply = 1'b1;
                    n_state = S_FMT_INIT;
                end else if (i_stat.func == FN_CREATE) begin
                    if (i_stat.hit) begin
                        o_cmd.res_status = ST_EXISTS;
                    end else if (i_stat.has_free) begin
                        o_cmd.op = OP_CREATE;
                    end else begin
                        o_cmd.res_status = ST_DIRFULL;
                    end
                end else if (!i_stat.hit) begin
                    o_cmd.res_status = ST_NOTFOUND;
                end else if (i_stat.func == FN_APPEND) begin
                    if (i_stat.head_zero) begin
                        o_cmd.res_status = ST_NOSPACE;
                    end else begin
                        o_cmd.res_en = 1'b0;
                        o_cmd.op     = OP_RD_HEAD;
                        n_state      = S_APP_UNLINK;
                    end
                end else if (i_stat.func == FN_REMOVE) begin
                    o_cmd.res_en = 1'b0;
                    o_cmd.op     = OP_WALK_INIT;
                    n_state      = S_REM_TEST;
                end else if (i_stat.func == FN_FIRST) begin
                    o_cmd.res_sel = SEL_FIRST;
                end else begin
                    // delete, check and next
                    if (i_stat.first_zero) begin
                        o_cmd.res_status = ST_EMPTY;
                    end else if (i_stat.blk_zero) begin
                        o_cmd.res_status = ST_NOTIN;
                    end else begin
                        o_cmd.res_en = 1'b0;
                        o_cmd.op     = OP_WALK_INIT;
                        n_state      = S_FIND_TEST;
                    end
                end
            end
            S_APP_UNLINK: begin
                o_cmd.op = OP_UNLINK;
                if (i_stat.first_zero) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = SEL_A;
                    n_state       = S_RESULT;
                end else begin
                    n_state = S_APP_RD;
                end
            end
            S_APP_RD: begin
                o_cmd.op = OP_RD_N;
                n_state  = S_APP_EVAL;
            end
            S_APP_EVAL: begin
                if (i_stat.rd_zero || i_stat.steps_done) begin
                    o_cmd.op      = OP_LINK;
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = SEL_A;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.op = OP_ADV;
                    n_state  = S_APP_RD;
                end
            end
            S_FIND_TEST: begin
                if (i_stat.steps_done || i_stat.n_zero) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = ST_NOTIN;
                    n_state          = S_RESULT;
                end else if (i_stat.n_eq_blk) begin
                    if (i_stat.func == FN_CHECK) begin
                        o_cmd.res_en = 1'b1;
                        n_state      = S_RESULT;
                    end else begin
                        o_cmd.op = OP_RD_N;
                        n_state  = (i_stat.func == FN_NEXT) ? S_NEXT_OUT : S_DEL_LINK;
                    end
                end else begin
                    o_cmd.op = OP_RD_N;
                    n_state  = S_FIND_ADV;
                end
            end
            S_FIND_ADV: begin
                o_cmd.op = OP_FIND_ADV;
                n_state  = S_FIND_TEST;
            end
            S_NEXT_OUT: begin
                o_cmd.res_en  = 1'b1;
                o_cmd.res_sel = SEL_RD;
                n_state       = S_RESULT;
            end
            S_DEL_LINK: begin
                o_cmd.op = OP_DEL_LINK;
                n_state  = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                o_cmd.op     = OP_FREE_N;
                o_cmd.res_en = 1'b1;
                n_state      = S_RESULT;
            end
            S_REM_TEST: begin
                if (i_stat.steps_done || i_stat.n_zero) begin
                    o_cmd.op     = OP_CLEAR;
                    o_cmd.res_en = 1'b1;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.op = OP_RD_N;
                    n_state  = S_REM_STEP;
                end
            end
            S_REM_STEP: begin
                o_cmd.op = OP_FREE_N;
                n_state  = S_REM_TEST;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FMT_INIT;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SCAN))
        else $error("accepted request did not start the directory scan");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_stat.out_free)
        else $error("result published over an unread result");

    a_read_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_RD_N) |-> !i_stat.n_zero)
        else $error("chain walk read at block zero");

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !i_stat.scan_match && !i_stat.scan_last)
        |=> (r_state == S_SCAN))
        else $error("directory scan ended early");

endmodule

// ===== sim/fat_chain_block_manager_tb.sv =====
// ----------------------------------------------------------------------------
// fat_chain_block_manager_tb
// Self-checking bench for the allocation table manager: a shadow copy of the
// table and directory predicts every result, and requests run in several
// register settings with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module fat_chain_block_manager_tb;
    import fcbm_pkg::*;

    localparam int SLOTS      = 16;
    localparam int PER_PHASE  = 180;
    localparam int CYCLE_CAP  = 20000000;

    // ------------------------------------------------------------------------
    // Shadow of the table and directory; holds the expected result queue.
    // ------------------------------------------------------------------------
    class fat_shadow;
        int unsigned      total_cfg;
        int unsigned      resv_cfg;
        logic [BLK_W-1:0] tab [MAX_BLOCKS];
        logic [KEY_W-1:0] keys [SLOTS];
        bit               used [SLOTS];
        logic [BLK_W-1:0] first [SLOTS];
        t_out_item        pending_results [$];
        int               mismatches;

        function new();
            total_cfg  = 1024;
            resv_cfg   = 1;
            mismatches = 0;
            format_table();
        endfunction

        function void format_table();
            int unsigned t;
            int unsigned r;
            t = total_cfg;
            r = resv_cfg;
            if (t < 2) t = 2;
            if (t > MAX_BLOCKS) t = MAX_BLOCKS;
            if (r > t - 1) r = t - 1;
            foreach (tab[i]) tab[i] = '0;
            for (int unsigned i = 1; i <= r; i++) tab[i] = BLK_W'(i);
            for (int unsigned i = r + 1; i < t; i++)
                tab[i] = (i + 1 < t) ? BLK_W'(i + 1) : '0;
            tab[0] = (r + 1 < t) ? BLK_W'(r + 1) : '0;
            foreach (used[s]) begin
                used[s]  = 0;
                keys[s]  = '0;
                first[s] = '0;
            end
        endfunction

        function int find_slot(logic [KEY_W-1:0] k);
            for (int s = 0; s < SLOTS; s++)
                if (used[s] && keys[s] == k) return s;
            return -1;
        endfunction

        function void free_blk(logic [BLK_W-1:0] b);
            tab[b] = tab[0];
            tab[0] = b;
        endfunction

        // Pick a block that lies on the file's chain, or any block if none.
        function logic [BLK_W-1:0] pick_block(logic [KEY_W-1:0] k);
            logic [BLK_W-1:0] chain [$];
            logic [BLK_W-1:0] n;
            int               s;
            s = find_slot(k);
            if (s >= 0) begin
                n = first[s];
                for (int st = 0; st < MAX_BLOCKS && n != 0; st++) begin
                    chain = {chain, n};
                    n = tab[n];
                end
            end
            if (chain.size() == 0) return BLK_W'($urandom);
            return chain[$urandom_range(0, chain.size() - 1)];
        endfunction

        function void log_request(t_in_item it);
            t_out_item        res;
            logic [BLK_W-1:0] a, n, p, nx;
            int               s;
            bit               hit;
            res.status      = ST_OK;
            res.block_value = '0;
            s = find_slot(it.file_key);
            if (it.func == FN_FORMAT) begin
                format_table();
            end else if (it.func == FN_CREATE) begin
                if (s >= 0) begin
                    res.status = ST_EXISTS;
                end else begin
                    res.status = ST_DIRFULL;
                    for (int f = 0; f < SLOTS; f++) begin
                        if (!used[f]) begin
                            used[f]    = 1;
                            keys[f]    = it.file_key;
                            first[f]   = '0;
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
            end else if (s < 0) begin
                res.status = ST_NOTFOUND;
            end else if (it.func == FN_APPEND) begin
                a = tab[0];
                if (a == 0) begin
                    res.status = ST_NOSPACE;
                end else begin
                    tab[0] = tab[a];
                    tab[a] = '0;
                    if (first[s] == 0) begin
                        first[s] = a;
                    end else begin
                        n = first[s];
                        for (int st = 0; st < MAX_BLOCKS && tab[n] != 0; st++) n = tab[n];
                        tab[n] = a;
                    end
                    res.block_value = a;
                end
            end else if (it.func inside {FN_DELETE, FN_CHECK, FN_NEXT}) begin
                // walk the chain for the block and remember its predecessor
                hit = 0;
                p   = '0;
                n   = first[s];
                for (int st = 0; st < MAX_BLOCKS && n != 0; st++) begin
                    if (n == it.block_number) begin
                        hit = 1;
                        break;
                    end
                    p = n;
                    n = tab[n];
                end
                if (first[s] == 0) begin
                    res.status = ST_EMPTY;
                end else if (it.block_number == 0 || !hit) begin
                    res.status = ST_NOTIN;
                end else if (it.func == FN_DELETE) begin
                    if (p == 0) first[s] = tab[it.block_number];
                    else tab[p] = tab[it.block_number];
                    free_blk(it.block_number);
                end else if (it.func == FN_NEXT) begin
                    res.block_value = tab[it.block_number];
                end
            end else if (it.func == FN_REMOVE) begin
                n = first[s];
                for (int st = 0; st < MAX_BLOCKS && n != 0; st++) begin
                    nx = tab[n];
                    free_blk(n);
                    n = nx;
                end
                first[s] = '0;
                used[s]  = 0;
                keys[s]  = '0;
            end else begin
                res.block_value = first[s];
            end
            pending_results = {pending_results, res};
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result %0d/%0d", got.status, got.block_value));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.block_value !== want.block_value)
                    report($sformatf("block %0d, want %0d", got.block_value, want.block_value));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    fat_shadow        shadow;
    int               cycle_count;
    int               stall_mode;
    logic [KEY_W-1:0] key_pool [20];

    fat_chain_block_manager u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: stalls in one of three random patterns (none, light, heavy).
    always @(negedge i_clk) begin
        if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) shadow.check_result(o_out_item);
    end

    // Drive one request; called at a falling edge, returns at a falling edge.
    // Valid stays high afterwards so a burst continues without a dip.
    task send_request(logic [2:0] fn, logic [KEY_W-1:0] k, logic [BLK_W-1:0] b);
        t_in_item it;
        it.func         = fn;
        it.file_key     = k;
        it.block_number = b;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        shadow.log_request(it);
        @(negedge i_clk);
    endtask

    task idle_gap(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Write a register only once every result has drained and the block idles.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        idle_gap(1);
        while (shadow.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TOTAL) shadow.total_cfg = 32'(val);
        else shadow.resv_cfg = 32'(val);
    endtask

    task random_phase(int count);
        int          burst;
        int          r;
        logic [2:0]  fn;
        logic [KEY_W-1:0] k;
        logic [BLK_W-1:0] b;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < 1)       fn = FN_FORMAT;
            else if (r < 21) fn = FN_CREATE;
            else if (r < 48) fn = FN_APPEND;
            else if (r < 60) fn = FN_DELETE;
            else if (r < 70) fn = FN_CHECK;
            else if (r < 80) fn = FN_NEXT;
            else if (r < 88) fn = FN_REMOVE;
            else             fn = FN_FIRST;
            k = ($urandom_range(0, 19) == 0) ? KEY_W'($urandom)
                                             : key_pool[$urandom_range(0, 19)];
            // mostly aim at blocks on the chain, sometimes anywhere
            b = ($urandom_range(0, 9) < 6) ? shadow.pick_block(k) : BLK_W'($urandom);
            send_request(fn, k, b);
        end
    endtask

    initial begin
        int unsigned totals [6] = '{2, 1024, 37, 10, 300, 1024};
        int unsigned resvs  [6] = '{1, 1022, 4, 1022, 1, 1};
        logic [BLK_W-1:0] mid;
        shadow      = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_TOTAL;
        i_cfg_data  <= '0;
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unknown key, create/exists, empty file, chain edges,
        // unlink first and middle blocks, directory overflow, remove.
        write_reg(CFG_TOTAL, 11'd1024);
        write_reg(CFG_RESERVED, 11'd1);
        send_request(FN_FORMAT, '0, '0);
        send_request(FN_APPEND, 16'h0000, '0);
        send_request(FN_FIRST, 16'hffff, '0);
        send_request(FN_CREATE, 16'h0000, '0);
        send_request(FN_CREATE, 16'h0000, '0);
        send_request(FN_FIRST, 16'h0000, '0);
        send_request(FN_CHECK, 16'h0000, 10'd5);
        send_request(FN_NEXT, 16'h0000, 10'd5);
        repeat (3) send_request(FN_APPEND, 16'h0000, '0);
        mid = shadow.tab[shadow.first[0]];
        send_request(FN_FIRST, 16'h0000, '0);
        send_request(FN_NEXT, 16'h0000, mid);
        send_request(FN_CHECK, 16'h0000, 10'd0);
        send_request(FN_CHECK, 16'h0000, 10'd1023);
        send_request(FN_DELETE, 16'h0000, mid);
        send_request(FN_DELETE, 16'h0000, shadow.first[0]);
        send_request(FN_CREATE, 16'hffff, '0);
        for (int i = 2; i < 17; i++) send_request(FN_CREATE, key_pool[i], '0);
        send_request(FN_REMOVE, 16'h0000, '0);
        send_request(FN_REMOVE, 16'hffff, '0);
        random_phase(PER_PHASE);

        // Sweep the register settings, extremes and clamping included.
        foreach (totals[p]) begin
            write_reg(CFG_TOTAL, CFG_W'(totals[p]));
            write_reg(CFG_RESERVED, CFG_W'(resvs[p]));
            foreach (key_pool[i]) if (i > 1) key_pool[i] = KEY_W'($urandom);
            send_request(FN_FORMAT, KEY_W'($urandom), BLK_W'($urandom));
            random_phase(PER_PHASE);
        end

        idle_gap(1);
        while (shadow.pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (shadow.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/fcbm_pkg.sv
design/fcbm_datapath.sv
design/fcbm_ctrl.sv
design/fat_chain_block_manager.sv
sim/fat_chain_block_manager_tb.sv
